@@ design/dstg_pkg.sv @@
// Shared types and constants of the DMX strobe timing generator.
`default_nettype none

package dstg_pkg;

	localparam int LEN_W     = 16;  // period and phase lengths, config registers
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FASTEST = 1'b1;

	localparam logic [LEN_W-1:0] RST_SLOWEST = 16'd1000;
	localparam logic [LEN_W-1:0] RST_FASTEST = 16'd50;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_FRAME = 1'b1;

	localparam logic [7:0] BLANK_MAX = 8'd4;
	localparam logic [7:0] DUR_MIN   = 8'd5;
	localparam logic [7:0] DUR_MAX   = 8'd250;

	// Constant divisors and their reciprocals scaled by 2^RECIP_SH.
	localparam int RATE_DIV = 255;
	localparam int DUR_SPAN = 245;
	localparam int RECIP_W  = 25;
	localparam int RECIP_SH = 32;
	localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843009;
	localparam logic [RECIP_W-1:0] RECIP_245 = 25'd17530478;

	localparam logic [LEN_W-1:0] MIN_PERIOD = 16'd2;

	// Cycles of the length pipeline between capture and update.
	localparam int CALC_LAT = 6;

	typedef struct packed {
		logic       req_type;
		logic [7:0] intensity;
		logic [7:0] rate;
		logic [7:0] duration;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] pwm_level;
		logic       lamp_lit;
	} res_item_t;

	typedef struct packed {
		logic cap;
		logic upd;
	} ctl_t;

	typedef struct packed {
		logic is_frame;
	} sts_t;

endpackage

`default_nettype wire

@@ design/dstg_stream_if.sv @@
// Valid/ready stream channel carrying one payload word.
`default_nettype none

interface dstg_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/dstg_ctrl.sv @@
// Controller state machine: sequences capture, length calculation and update.
`default_nettype none

module dstg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output logic          res_valid,
	input  logic          res_ready,
	output dstg_pkg::ctl_t ctl,
	input  dstg_pkg::sts_t sts
);
	import dstg_pkg::*;

	localparam int CNT_W = $clog2(CALC_LAT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             res_valid_q;

	assign cmd_ready = (state_q == ST_IDLE);
	assign ctl.cap   = cmd_valid && cmd_ready;
	assign ctl.upd   = (state_q == ST_UPD) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.cap) begin
					state_d = ST_CALC;
					cnt_d   = CNT_W'(CALC_LAT - 1);
				end
			end
			ST_CALC: begin
				// ticks need no lengths
				if (!sts.is_frame || cnt_q == '0) begin
					state_d = ST_UPD;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_UPD: begin
				if (ctl.upd) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctl.upd) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/dstg_datapath.sv @@
// Datapath: config registers, length pipeline, strobe phase state, output word.
`default_nettype none

module dstg_datapath #(
	parameter int TIME_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dstg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dstg_pkg::LEN_W-1:0]       cfg_data,
	input  dstg_pkg::cmd_item_t              item,
	input  dstg_pkg::ctl_t                   ctl,
	output dstg_pkg::sts_t                   sts,
	output dstg_pkg::res_item_t              result
);
	import dstg_pkg::*;

	localparam int CW      = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;
	localparam int PROD1_W = LEN_W + 10;   // 9-bit rate times 17-bit signed difference
	localparam int ABS_W   = LEN_W + 8;    // magnitude of either product
	localparam int MUL_W   = ABS_W + RECIP_W;
	localparam int SUM_W   = LEN_W + 2;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// configuration
	logic [LEN_W-1:0] slowest_q;
	logic [LEN_W-1:0] fastest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slowest_q <= RST_SLOWEST;
			fastest_q <= RST_FASTEST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOWEST: slowest_q <= cfg_data;
				CFG_FASTEST: fastest_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured word
	logic       req_q;
	logic [7:0] inten_q;
	logic [7:0] rate_q;
	logic [7:0] dur_q;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			req_q   <= item.req_type;
			inten_q <= item.intensity;
			rate_q  <= item.rate;
			dur_q   <= item.duration;
		end
	end

	assign sts.is_frame = (req_q == REQ_FRAME);

	// stage 1: rate times period span, saturated duration offset
	logic signed [PROD1_W-1:0] rate_ext;
	logic signed [PROD1_W-1:0] diff_ext;
	logic signed [PROD1_W-1:0] prod1_s1;
	logic [7:0]                dm5_s1;

	assign rate_ext = $signed({{(PROD1_W-8){1'b0}}, rate_q});
	assign diff_ext = $signed({{(PROD1_W-LEN_W){1'b0}}, fastest_q})
		- $signed({{(PROD1_W-LEN_W){1'b0}}, slowest_q});

	always_ff @(posedge clk) begin
		prod1_s1 <= rate_ext * diff_ext;
		if (dur_q < DUR_MIN) begin
			dm5_s1 <= '0;
		end else if (dur_q > DUR_MAX) begin
			dm5_s1 <= DUR_MAX - DUR_MIN;
		end else begin
			dm5_s1 <= dur_q - DUR_MIN;
		end
	end

	// stage 2: magnitude and reciprocal estimate of /255
	logic signed [PROD1_W-1:0] neg1;
	logic [ABS_W-1:0]          abs1;
	logic [MUL_W-1:0]          mul1;
	logic [ABS_W-1:0]          abs_s2;
	logic [LEN_W-1:0]          qe_s2;
	logic                      neg_s2;
	logic [7:0]                dm5_s2;

	assign neg1 = -prod1_s1;
	assign abs1 = prod1_s1[PROD1_W-1] ? neg1[ABS_W-1:0] : prod1_s1[ABS_W-1:0];
	assign mul1 = {{RECIP_W{1'b0}}, abs1} * {{ABS_W{1'b0}}, RECIP_255};

	always_ff @(posedge clk) begin
		abs_s2 <= abs1;
		qe_s2  <= mul1[RECIP_SH+LEN_W-1:RECIP_SH];
		neg_s2 <= prod1_s1[PROD1_W-1];
		dm5_s2 <= dm5_s1;
	end

	// stage 3: correct quotient, restore sign, add slowest period, clamp
	logic [ABS_W-1:0]        back1;
	logic [ABS_W-1:0]        rem1;
	logic [LEN_W-1:0]        q1;
	logic signed [SUM_W-1:0] sq1;
	logic signed [SUM_W-1:0] p_sum;
	logic [LEN_W-1:0]        p_s3;
	logic [7:0]              dm5_s3;

	assign back1 = ABS_W'({{(ABS_W-LEN_W){1'b0}}, qe_s2} * RATE_DIV);
	assign rem1  = abs_s2 - back1;
	assign q1    = qe_s2 + LEN_W'(rem1 >= ABS_W'(RATE_DIV));
	assign sq1   = neg_s2 ? -$signed({2'b00, q1}) : $signed({2'b00, q1});
	assign p_sum = sq1 + $signed({2'b00, slowest_q});

	always_ff @(posedge clk) begin
		if (p_sum < $signed({2'b00, MIN_PERIOD})) begin
			p_s3 <= MIN_PERIOD;
		end else begin
			p_s3 <= p_sum[LEN_W-1:0];
		end
		dm5_s3 <= dm5_s2;
	end

	// stage 4: duration offset times usable span
	logic [ABS_W-1:0] prod2_s4;
	logic [LEN_W-1:0] p_s4;

	always_ff @(posedge clk) begin
		prod2_s4 <= {{(ABS_W-8){1'b0}}, dm5_s3} * {{(ABS_W-LEN_W){1'b0}}, p_s3 - MIN_PERIOD};
		p_s4     <= p_s3;
	end

	// stage 5: reciprocal estimate of /245
	logic [MUL_W-1:0] mul2;
	logic [LEN_W-1:0] qe2_s5;
	logic [ABS_W-1:0] prod2_s5;
	logic [LEN_W-1:0] p_s5;

	assign mul2 = {{RECIP_W{1'b0}}, prod2_s4} * {{ABS_W{1'b0}}, RECIP_245};

	always_ff @(posedge clk) begin
		qe2_s5   <= mul2[RECIP_SH+LEN_W-1:RECIP_SH];
		prod2_s5 <= prod2_s4;
		p_s5     <= p_s4;
	end

	// stage 6: correct quotient, split period into on and off time
	logic [ABS_W-1:0] back2;
	logic [ABS_W-1:0] rem2;
	logic [LEN_W-1:0] on_calc;
	logic [LEN_W-1:0] on_s6;
	logic [LEN_W-1:0] off_s6;

	assign back2   = ABS_W'({{(ABS_W-LEN_W){1'b0}}, qe2_s5} * DUR_SPAN);
	assign rem2    = prod2_s5 - back2;
	assign on_calc = qe2_s5 + LEN_W'(rem2 >= ABS_W'(DUR_SPAN)) + 1'b1;

	always_ff @(posedge clk) begin
		on_s6  <= on_calc;
		off_s6 <= p_s5 - on_calc;
	end

	// strobe state
	logic                 running_q,  running_d;
	logic                 phase_on_q, phase_on_d;
	logic [7:0]           duty_q,     duty_d;
	logic [LEN_W-1:0]     on_len_q,   on_len_d;
	logic [LEN_W-1:0]     off_len_q,  off_len_d;
	logic [LEN_W-1:0]     tgt_q,      tgt_d;
	logic [TIME_BITS-1:0] el_q,       el_d;
	logic [7:0]           prate_q,    prate_d;
	logic [7:0]           pint_q,     pint_d;
	logic [7:0]           pdur_q,     pdur_d;

	logic                 is_frame;
	logic                 dur_ok;
	logic                 rate_chg;
	logic                 int_chg;
	logic [7:0]           lit_level;
	logic [TIME_BITS-1:0] el_inc;
	logic [LEN_W-1:0]     new_tgt;
	logic                 toggle;

	assign is_frame  = (req_q == REQ_FRAME);
	assign dur_ok    = (dur_q >= DUR_MIN) && (dur_q <= DUR_MAX);
	assign rate_chg  = (rate_q != prate_q);
	assign int_chg   = (inten_q != pint_q);
	assign pint_d    = is_frame ? inten_q : pint_q;
	assign pdur_d    = is_frame ? dur_q : pdur_q;
	assign prate_d   = is_frame ? rate_q : prate_q;
	assign lit_level = (pdur_d <= BLANK_MAX) ? 8'd0 : pint_d;
	assign el_inc    = (el_q != TIME_MAX) ? el_q + 1'b1 : el_q;
	assign on_len_d  = (is_frame && (!running_q || dur_ok)) ? on_s6 : on_len_q;
	assign off_len_d = (is_frame && (!running_q || dur_ok)) ? off_s6 : off_len_q;
	assign new_tgt   = phase_on_q ? on_len_d : off_len_d;

	always_comb begin
		running_d  = running_q;
		phase_on_d = phase_on_q;
		duty_d     = duty_q;
		tgt_d      = tgt_q;
		el_d       = el_q;
		toggle     = 1'b0;
		if (!is_frame) begin
			if (running_q) begin
				el_d = el_inc;
				if (CW'(el_inc) >= CW'(tgt_q) || el_inc == TIME_MAX) begin
					toggle = 1'b1;
				end
			end
		end else if (!running_q) begin
			// first frame: enter the on phase from off
			running_d = 1'b1;
			toggle    = 1'b1;
		end else if (rate_chg) begin
			// re-time the current phase against time already spent
			tgt_d = new_tgt;
			if (CW'(el_q) >= CW'(new_tgt)) begin
				toggle = 1'b1;
			end
		end
		if (toggle) begin
			if (phase_on_q) begin
				phase_on_d = 1'b0;
				duty_d     = 8'd0;
				tgt_d      = off_len_d;
			end else begin
				phase_on_d = 1'b1;
				duty_d     = lit_level;
				tgt_d      = on_len_d;
			end
			el_d = '0;
		end
		if (is_frame && running_q && int_chg && phase_on_d) begin
			duty_d = lit_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			phase_on_q <= 1'b0;
			duty_q     <= '0;
			on_len_q   <= '0;
			off_len_q  <= '0;
			tgt_q      <= '0;
			el_q       <= '0;
			prate_q    <= '0;
			pint_q     <= '0;
			pdur_q     <= '0;
		end else if (ctl.upd) begin
			running_q  <= running_d;
			phase_on_q <= phase_on_d;
			duty_q     <= duty_d;
			on_len_q   <= on_len_d;
			off_len_q  <= off_len_d;
			tgt_q      <= tgt_d;
			el_q       <= el_d;
			prate_q    <= prate_d;
			pint_q     <= pint_d;
			pdur_q     <= pdur_d;
		end
	end

	// output word register
	res_item_t res_q;

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			res_q.pwm_level <= duty_d;
			res_q.lamp_lit  <= phase_on_d;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

@@ design/dmx_strobe_timing_generator.sv @@
// Top level of the DMX strobe timing generator.
//
// Each input word is either a one millisecond tick (req_type 0) or a DMX frame
// (req_type 1) carrying intensity, rate and duration; every word produces
// exactly one output word with the current PWM level and the lamp-lit flag.
// The rate channel sets the period linearly from slowest_period_ms (rate 0)
// to fastest_period_ms (rate 255); durations 5..250 set the on time from 1 ms
// up to period-1 ms, 0..4 blank the lamp. A tick goes from capture through the
// calculation and update states into the output register; a frame also walks a
// six-stage length pipeline (two variable products, two divisions by constants
// done as reciprocal multiplications) in the calculation state before the
// phase state is updated. The next word is accepted in the cycle after the load,
// and the load itself waits in the update state while a full output register
// has not yet been taken by the sink. One word is in flight at a time; the
// next word is accepted as soon as the previous one sits in the output
// register, even if the sink has not yet taken it. Config registers (index 0
// slowest, 1 fastest) take effect on the next frame and must only be written
// while no word is in flight. TIME_BITS sizes the phase elapsed counter, which
// saturates and ends the phase at its maximum.
`default_nettype none

module dmx_strobe_timing_generator #(
	parameter int TIME_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dstg_stream_if.sink                    cmd,
	dstg_stream_if.source                  res,
	input  logic                           cfg_we,
	input  logic [dstg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dstg_pkg::LEN_W-1:0]     cfg_data
);
	import dstg_pkg::*;

	ctl_t      ctl;
	sts_t      sts;
	logic      cmd_ready;
	logic      res_valid;
	res_item_t result;

	// Sequence each word: capture, walk the length pipeline, update once the
	// output register is free.
	dstg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Hold config, compute phase lengths, advance the strobe state.
	dstg_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (cmd.data),
		.ctl       (ctl),
		.sts       (sts),
		.result    (result)
	);

	assign cmd.ready = cmd_ready;
	assign res.valid = res_valid;
	assign res.data  = result;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the DMX strobe timing generator: queued stimulus, inline predictor.
module tb;
	import dstg_pkg::*;

	localparam int          CLK_HALF         = 6;
	localparam int          RESET_CYCLES     = 7;
	localparam int          DRAIN_CYCLES     = 24;     // leave a margin for the frame pipeline to drain
	localparam int          LONG_HOLD        = 300;    // receiver hold-off that backs up the input
	localparam int          RANDOM_PER_PHASE = 205;
	localparam int          NUM_PHASES       = 7;
	localparam int          CYCLE_LIMIT      = 400000;
	localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;

	dstg_stream_if #(.payload_t(cmd_item_t)) cmd_if ();
	dstg_stream_if #(.payload_t(res_item_t)) res_if ();

	dmx_strobe_timing_generator #(
		.TIME_BITS(16)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Stimulus and expectation stores.
	cmd_item_t   pend_words [$];
	res_item_t   exp_results [$];
	int unsigned words_queued = 0;
	int unsigned words_sent   = 0;
	int unsigned errors       = 0;
	int unsigned cycle_count  = 0;

	// Idle knobs, percent per cycle.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_go        = 1'b0;
	int unsigned hold_left      = 0;
	logic        cmd_fire       = 1'b0;

	// Per-phase register settings.
	int slow_tbl [NUM_PHASES];
	int fast_tbl [NUM_PHASES];
	int mode_tbl [NUM_PHASES];

	// Random generator memory, so frames can repeat rate or intensity.
	logic [7:0] gen_rate  = 8'd0;
	logic [7:0] gen_inten = 8'd0;

	// Predictor copy of the registers and the strobe state.
	logic [LEN_W-1:0] cfg_slow_ms;
	logic [LEN_W-1:0] cfg_fast_ms;
	logic             strobe_running;
	logic             phase_lit;
	logic [7:0]       duty_now;
	logic [LEN_W-1:0] on_ms;
	logic [LEN_W-1:0] off_ms;
	logic [LEN_W-1:0] target_ms;
	logic [LEN_W-1:0] elapsed_ms;
	logic [7:0]       last_rate;
	logic [7:0]       last_inten;
	logic [7:0]       last_dur;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Period from the rate, then on time from the duration (saturated into the
	// scaled range); both quotients truncate toward zero.
	function automatic void derive_lengths(input logic [7:0] rate, input logic [7:0] dur);
		longint s;
		longint f;
		longint p;
		longint on_t;
		int     d;
		s = cfg_slow_ms;
		f = cfg_fast_ms;
		p = (longint'(rate) * (f - s)) / RATE_DIV + s;
		if (p < longint'(MIN_PERIOD)) begin
			p = MIN_PERIOD;
		end
		d = dur;
		if (d < int'(DUR_MIN)) begin
			d = DUR_MIN;
		end
		if (d > int'(DUR_MAX)) begin
			d = DUR_MAX;
		end
		on_t = (longint'(d - int'(DUR_MIN)) * (p - longint'(MIN_PERIOD))) / DUR_SPAN + 1;
		on_ms = on_t[LEN_W-1:0];
		off_ms = LEN_W'(p - on_t);
	endfunction

	// Light up: a blackout duration keeps the lamp dark even in the on phase.
	function automatic void light_up();
		duty_now = (last_dur <= BLANK_MAX) ? 8'd0 : last_inten;
	endfunction

	function automatic void flip_phase();
		if (phase_lit) begin
			phase_lit = 1'b0;
			duty_now = 8'd0;
			target_ms = off_ms;
		end else begin
			phase_lit = 1'b1;
			light_up();
			target_ms = on_ms;
		end
		elapsed_ms = '0;
	endfunction

	// Advance the strobe state by one word and return the output it leaves.
	function automatic res_item_t strobe_next(input cmd_item_t w);
		logic      rate_chg;
		logic      inten_chg;
		res_item_t r;
		if (w.req_type == REQ_TICK) begin
			// Ticks before the first frame do nothing.
			if (strobe_running) begin
				if (elapsed_ms < ELAPSED_MAX) begin
					elapsed_ms = elapsed_ms + 1'b1;
				end
				if (elapsed_ms >= target_ms || elapsed_ms == ELAPSED_MAX) begin
					flip_phase();
				end
			end
		end else if (!strobe_running) begin
			// First frame: start in the on phase.
			strobe_running = 1'b1;
			derive_lengths(w.rate, w.duration);
			last_rate = w.rate;
			last_inten = w.intensity;
			last_dur = w.duration;
			phase_lit = 1'b0;
			flip_phase();
		end else begin
			rate_chg = (w.rate != last_rate);
			inten_chg = (w.intensity != last_inten);
			if (w.duration >= DUR_MIN && w.duration <= DUR_MAX) begin
				derive_lengths(w.rate, w.duration);
			end
			last_rate = w.rate;
			last_inten = w.intensity;
			last_dur = w.duration;
			// Re-time the current phase; toggle at once if it is already over.
			if (rate_chg) begin
				target_ms = phase_lit ? on_ms : off_ms;
				if (elapsed_ms >= target_ms) begin
					flip_phase();
				end
			end
			if (inten_chg && phase_lit) begin
				light_up();
			end
		end
		r.pwm_level = duty_now;
		r.lamp_lit = phase_lit;
		return r;
	endfunction

	function automatic cmd_item_t make_word(input logic req, input logic [7:0] inten,
		input logic [7:0] rate, input logic [7:0] dur);
		cmd_item_t w;
		w.req_type = req;
		w.intensity = inten;
		w.rate = rate;
		w.duration = dur;
		return w;
	endfunction

	// Mostly ticks with random filler; frames mix repeated and fresh channels
	// and all three duration bands.
	function automatic cmd_item_t random_word();
		cmd_item_t w;
		int        pick;
		w.intensity = 8'($urandom_range(255));
		w.rate = 8'($urandom_range(255));
		w.duration = 8'($urandom_range(255));
		if ($urandom_range(99) >= 22) begin
			w.req_type = REQ_TICK;
			return w;
		end
		w.req_type = REQ_FRAME;
		pick = $urandom_range(9);
		if (pick < 3) begin
			w.rate = gen_rate;
		end else if (pick == 3) begin
			w.rate = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
		end
		if ($urandom_range(9) < 4) begin
			w.intensity = gen_inten;
		end
		pick = $urandom_range(9);
		if (pick == 0) begin
			w.duration = 8'($urandom_range(BLANK_MAX));
		end else if (pick == 1) begin
			w.duration = 8'($urandom_range(255, DUR_MAX + 1));
		end else if (pick == 2) begin
			w.duration = ($urandom_range(1) != 0) ? DUR_MAX : DUR_MIN;
		end else begin
			w.duration = 8'($urandom_range(DUR_MAX, DUR_MIN));
		end
		gen_rate = w.rate;
		gen_inten = w.intensity;
		return w;
	endfunction

	task automatic queue_word(input cmd_item_t w);
		pend_words.push_back(w);
		words_queued++;
	endtask

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Write one register on an idle block and mirror it in the predictor.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SLOWEST) begin
			cfg_slow_ms = val;
		end else begin
			cfg_fast_ms = val;
		end
	endtask

	// Wait until every queued word went in and its result came back, then let
	// the pipeline run dry.
	task automatic settle();
		while (words_sent != words_queued || exp_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Driver: hold the word until it is taken, then offer the next or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else if (!cmd_if.valid || cmd_fire) begin
			if (pend_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_if.data <= pend_words.pop_front();
				cmd_if.valid <= 1'b1;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// Long hold-off of the receiver, counted here.
	always @(negedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: stall at random, and fully during a hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check the result first, so a result with nothing waiting is not
	// matched against the word accepted at the same edge.
	always @(posedge clk) begin
		res_item_t got;
		res_item_t want;
		if (!arst_n) begin
			cmd_fire = 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (exp_results.size() == 0) begin
					flag_error($sformatf("unexpected result pwm=%0d lit=%0b",
						got.pwm_level, got.lamp_lit));
				end else begin
					want = exp_results.pop_front();
					if (got.pwm_level !== want.pwm_level) begin
						flag_error($sformatf("pwm_level mismatch: expected %0d, got %0d",
							want.pwm_level, got.pwm_level));
					end
					if (got.lamp_lit !== want.lamp_lit) begin
						flag_error($sformatf("lamp_lit mismatch: expected %0b, got %0b",
							want.lamp_lit, got.lamp_lit));
					end
				end
			end
			cmd_fire = cmd_if.valid && cmd_if.ready;
			if (cmd_fire) begin
				exp_results.push_back(strobe_next(cmd_if.data));
				words_sent++;
			end
		end
	end

	// Drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int ph;
		int i;
		int mode;

		cfg_we = 1'b0;
		cfg_index = CFG_SLOWEST;
		cfg_data = '0;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		res_if.ready = 1'b0;

		cfg_slow_ms = RST_SLOWEST;
		cfg_fast_ms = RST_FASTEST;
		strobe_running = 1'b0;
		phase_lit = 1'b0;
		duty_now = 8'd0;
		on_ms = '0;
		off_ms = '0;
		target_ms = '0;
		elapsed_ms = '0;
		last_rate = 8'd0;
		last_inten = 8'd0;
		last_dur = 8'd0;

		// Fast periods, degenerate and extreme registers, inverted slope.
		slow_tbl = '{20, 2, 65535, 3, 0, 65535, 12};
		fast_tbl = '{4, 2, 2, 40, 1, 65535, 7};
		// 0 no idling, 1 sender idles, 2 receiver stalls, 3 both.
		mode_tbl = '{0, 1, 2, 3, 0, 1, 2};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset register values.
		@(posedge clk);
		// Ticks before the first frame are ignored.
		queue_word(make_word(REQ_TICK, 8'd255, 8'd255, 8'd255));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		// First frame with a blackout duration: lit but dark, lengths saturated.
		queue_word(make_word(REQ_FRAME, 8'd255, 8'd0, 8'd2));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		// Rate jump to fastest: off phase already past its new length.
		queue_word(make_word(REQ_FRAME, 8'd255, 8'd255, DUR_MAX));
		// Intensity changes while lit.
		queue_word(make_word(REQ_FRAME, 8'd0, 8'd255, DUR_MAX));
		queue_word(make_word(REQ_FRAME, 8'd128, 8'd255, 8'd3));
		// Duration above the scaled range keeps the lengths.
		queue_word(make_word(REQ_FRAME, 8'd200, 8'd255, 8'd255));
		queue_word(make_word(REQ_FRAME, 8'd7, 8'd128, DUR_MIN));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_FRAME, 8'd7, 8'd200, 8'd128));
		queue_word(make_word(REQ_FRAME, 8'd255, 8'd0, BLANK_MAX));
		queue_word(make_word(REQ_FRAME, 8'd1, 8'd0, 8'd251));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_FRAME, 8'd90, 8'd255, 8'd0));
		queue_word(make_word(REQ_TICK, 8'd0, 8'd0, 8'd0));
		queue_word(make_word(REQ_FRAME, 8'd90, 8'd255, DUR_MIN));
		queue_word(make_word(REQ_TICK, 8'd255, 8'd255, 8'd255));
		settle();

		// Random phases, one register setting and one idle mode each.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(CFG_SLOWEST, LEN_W'(slow_tbl[ph]));
			write_reg(CFG_FASTEST, LEN_W'(fast_tbl[ph]));
			mode = mode_tbl[ph];
			send_idle_pct <= (mode == 1) ? 67 : (mode == 3) ? 27 : 0;
			recv_stall_pct <= (mode == 2) ? 67 : (mode == 3) ? 27 : 0;
			gen_rate = last_rate;
			gen_inten = last_inten;
			@(posedge clk);
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				queue_word(random_word());
			end
			// Back up the block while the sender keeps offering words.
			if (ph == 0) begin
				hold_go = 1'b1;
				@(posedge clk);
				hold_go = 1'b0;
			end
			settle();
		end

		errors += exp_results.size();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
